// ----- hdl/usvg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UV sphere vertex generator package
// Shared types, fixed-point constants and helper functions.
// ----------------------------------------------------------------------------
package usvg_pkg;

  localparam int MAX_PATCHES_DEF = 1024;
  localparam int TRIG_STAGES_DEF = 16;
  localparam int ATAN_COUNT      = 24;

  localparam int ANG_W = 18;
  localparam int CX_W  = 34;
  localparam int CA_W  = 38;
  localparam int TRIG_W = 32;

  localparam logic signed [CA_W-1:0] Q30_PI      = 38'sd3373259426;
  localparam logic signed [CA_W-1:0] Q30_HALF_PI = 38'sd1686629713;
  localparam logic signed [CA_W-1:0] Q30_TWO_PI  = 38'sd6746518852;
  localparam logic signed [CX_W-1:0] Q30_ONE     = 34'sd1073741824;
  localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [2:0] REG_RADIUS    = 3'd0;
  localparam logic [2:0] REG_LOW_U     = 3'd1;
  localparam logic [2:0] REG_HIGH_U    = 3'd2;
  localparam logic [2:0] REG_LOW_V     = 3'd3;
  localparam logic [2:0] REG_HIGH_V    = 3'd4;
  localparam logic [2:0] REG_PATCHES_U = 3'd5;
  localparam logic [2:0] REG_PATCHES_V = 3'd6;

  typedef struct packed {
    logic signed [ANG_W-1:0] ang_u;
    logic signed [ANG_W-1:0] ang_v;
    logic [16:0]             tex_u;
    logic [16:0]             tex_v;
    logic                    ok;
  } item_t;

  typedef struct packed {
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic        ok;
  } side_t;

  typedef struct packed {
    logic [15:0]        radius;
    logic signed [15:0] low_u;
    logic signed [15:0] high_u;
    logic signed [14:0] low_v;
    logic signed [14:0] high_v;
    logic [10:0]        patches_u;
    logic [10:0]        patches_v;
  } cfg_t;

  function automatic logic signed [CA_W-1:0] atan_q30(input int i);
    logic signed [CA_W-1:0] r;
    case (i)
      0: r = 38'sd843314856;
      1: r = 38'sd497837829;
      2: r = 38'sd263043836;
      3: r = 38'sd133525158;
      4: r = 38'sd67021686;
      5: r = 38'sd33543515;
      6: r = 38'sd16775850;
      7: r = 38'sd8388437;
      8: r = 38'sd4194282;
      9: r = 38'sd2097149;
      10: r = 38'sd1048575;
      11: r = 38'sd524287;
      12: r = 38'sd262143;
      13: r = 38'sd131071;
      14: r = 38'sd65535;
      15: r = 38'sd32767;
      16: r = 38'sd16383;
      17: r = 38'sd8191;
      18: r = 38'sd4095;
      19: r = 38'sd2047;
      20: r = 38'sd1023;
      21: r = 38'sd511;
      22: r = 38'sd255;
      23: r = 38'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [TRIG_W-1:0] clamp_q30(input logic signed [CX_W-1:0] v);
    logic signed [CX_W-1:0] r;
    if (v > Q30_ONE) begin
      r = Q30_ONE;
    end else if (v < -Q30_ONE) begin
      r = -Q30_ONE;
    end else begin
      r = v;
    end
    return r[TRIG_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/uv_sphere_vertex_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Turns grid index pairs into sphere vertices, normals and texture coordinates.
// ----------------------------------------------------------------------------
// One grid point is accepted every clock while the output is being taken. A
// transaction passes through one multiply stage, seventeen divider stages and
// one angle stage in the front end, a four-entry queue, then one fold stage,
// TRIG_STAGES CORDIC stages, one product stage and the output register in the
// back end; the dividers give one quotient bit per stage. Registers must be
// written through the APB port only while the block is idle; the block itself
// does not enforce this.
module uv_sphere_vertex_generator #(
  parameter int MAX_PATCHES = usvg_pkg::MAX_PATCHES_DEF,
  parameter int TRIG_STAGES = usvg_pkg::TRIG_STAGES_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [4:0]          paddr,
  input  wire [31:0]         pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire [10:0]         step_u,
  input  wire [10:0]         step_v,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [16:0] pos_x,
  output logic signed [16:0] pos_y,
  output logic signed [16:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [16:0]        tex_u,
  output logic [16:0]        tex_v,
  output logic               index_ok
);
  import usvg_pkg::*;

  cfg_t       cfg;
  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius    <= 16'd256;
      cfg.low_u     <= -16'sd25736;
      cfg.high_u    <= 16'sd25736;
      cfg.low_v     <= -15'sd12868;
      cfg.high_v    <= 15'sd12868;
      cfg.patches_u <= 11'd32;
      cfg.patches_v <= 11'd32;
    end else if (wr) begin
      case (idx)
        REG_RADIUS:    cfg.radius    <= pwdata[15:0];
        REG_LOW_U:     cfg.low_u     <= pwdata[15:0];
        REG_HIGH_U:    cfg.high_u    <= pwdata[15:0];
        REG_LOW_V:     cfg.low_v     <= pwdata[14:0];
        REG_HIGH_V:    cfg.high_v    <= pwdata[14:0];
        REG_PATCHES_U: cfg.patches_u <= pwdata[10:0];
        REG_PATCHES_V: cfg.patches_v <= pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RADIUS:    prdata = 32'(cfg.radius);
      REG_LOW_U:     prdata = 32'(unsigned'(cfg.low_u));
      REG_HIGH_U:    prdata = 32'(unsigned'(cfg.high_u));
      REG_LOW_V:     prdata = 32'(unsigned'(cfg.low_v));
      REG_HIGH_V:    prdata = 32'(unsigned'(cfg.high_v));
      REG_PATCHES_U: prdata = 32'(cfg.patches_u);
      REG_PATCHES_V: prdata = 32'(cfg.patches_v);
      default:       prdata = '0;
    endcase
  end

  logic  push, q_ready, q_valid, pop;
  item_t witem, ritem;

  usvg_front #(.MAX_PATCHES(MAX_PATCHES)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready),
    .step_u(step_u), .step_v(step_v),
    .push(push), .item(witem), .q_ready(q_ready)
  );

  usvg_queue u_queue (
    .clk(clk), .rst(rst),
    .push(push), .wdata(witem), .q_ready(q_ready),
    .pop(pop), .q_valid(q_valid), .rdata(ritem)
  );

  usvg_back #(.TRIG_STAGES(TRIG_STAGES)) u_back (
    .clk(clk), .rst(rst), .radius(cfg.radius),
    .q_valid(q_valid), .qdata(ritem), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .tex_u(tex_u), .tex_v(tex_v), .index_ok(index_ok)
  );

endmodule
`default_nettype wire

// ----- hdl/usvg_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces one quotient bit per stage; the denominator must be held steady by the user.
// ----------------------------------------------------------------------------
module usvg_divider #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 11,
  parameter int QUO_W = 17
) (
  input  wire              clk,
  input  wire              en,
  input  wire [NUM_W-1:0]  num,
  input  wire [DEN_W-1:0]  den,
  output logic [QUO_W-1:0] quo
);

  localparam int W = NUM_W + DEN_W + QUO_W;

  logic [W-1:0]     rem [0:QUO_W];
  logic [QUO_W-1:0] qv  [0:QUO_W];

  always_comb begin
    rem[0] = W'(num);
    qv[0]  = '0;
  end

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int B = QUO_W - 1 - s;
    logic [W-1:0] dsh;
    assign dsh = W'(den) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[s] >= dsh) begin
          rem[s+1] <= rem[s] - dsh;
          qv[s+1]  <= qv[s] | (QUO_W'(1) << B);
        end else begin
          rem[s+1] <= rem[s];
          qv[s+1]  <= qv[s];
        end
      end
    end
  end

  assign quo = qv[QUO_W];

endmodule
`default_nettype wire

// ----- hdl/usvg_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Accepts grid indices, checks them and works out the grid angles and
// texture coordinates through pipelined dividers.
// ----------------------------------------------------------------------------
module usvg_front #(
  parameter int MAX_PATCHES = usvg_pkg::MAX_PATCHES_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  usvg_pkg::cfg_t        cfg,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire [10:0]            step_u,
  input  wire [10:0]            step_v,
  output logic                  push,
  output usvg_pkg::item_t       item,
  input  wire                   q_ready
);
  import usvg_pkg::*;

  localparam int NUM_W = 28;
  localparam int QUO_W = 17;

  typedef struct packed {
    logic ok;
    logic neg_u;
    logic neg_v;
  } fside_t;

  logic             en;
  logic             va;
  logic [QUO_W-1:0] vd;
  logic             vc;
  fside_t           sd [0:QUO_W];
  logic [NUM_W-1:0] num_u, num_v, num_tu, num_tv;
  logic [QUO_W-1:0] quo_u, quo_v, quo_tu, quo_tv;

  logic signed [16:0] diff_u;
  logic signed [15:0] diff_v;
  logic signed [28:0] n_u;
  logic signed [27:0] n_v;
  logic [28:0]        mag_u;
  logic [27:0]        mag_v;
  logic               ok_in;

  assign en       = !vc || q_ready;
  assign in_ready = en;
  assign push     = vc && q_ready;

  always_comb begin
    diff_u = {cfg.high_u[15], cfg.high_u} - {cfg.low_u[15], cfg.low_u};
    diff_v = {cfg.high_v[14], cfg.high_v} - {cfg.low_v[14], cfg.low_v};
    n_u    = diff_u * $signed({1'b0, step_u});
    n_v    = diff_v * $signed({1'b0, step_v});
    mag_u  = n_u[28] ? 29'(-n_u) : 29'(n_u);
    mag_v  = n_v[27] ? 28'(-n_v) : 28'(n_v);
    ok_in  = (cfg.patches_u != '0) && (int'(cfg.patches_u) <= MAX_PATCHES) &&
             (cfg.patches_v != '0) && (int'(cfg.patches_v) <= MAX_PATCHES) &&
             (step_u <= cfg.patches_u) && (step_v <= cfg.patches_v);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_u  <= mag_u[NUM_W-1:0] + NUM_W'(cfg.patches_u >> 1);
      num_v  <= mag_v + NUM_W'(cfg.patches_v >> 1);
      num_tu <= NUM_W'({step_u, 16'b0}) + NUM_W'(cfg.patches_u >> 1);
      num_tv <= NUM_W'({step_v, 16'b0}) + NUM_W'(cfg.patches_v >> 1);
      sd[0]  <= '{ok: ok_in, neg_u: n_u[28], neg_v: n_v[27]};
      for (int s = 0; s < QUO_W; s++) begin
        sd[s+1] <= sd[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vd <= '0;
      vc <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vd <= {vd[QUO_W-2:0], va};
      vc <= vd[QUO_W-1];
    end
  end

  usvg_divider #(.NUM_W(NUM_W), .DEN_W(11), .QUO_W(QUO_W)) u_div_u (
    .clk(clk), .en(en), .num(num_u), .den(cfg.patches_u), .quo(quo_u)
  );
  usvg_divider #(.NUM_W(NUM_W), .DEN_W(11), .QUO_W(QUO_W)) u_div_v (
    .clk(clk), .en(en), .num(num_v), .den(cfg.patches_v), .quo(quo_v)
  );
  usvg_divider #(.NUM_W(NUM_W), .DEN_W(11), .QUO_W(QUO_W)) u_div_tu (
    .clk(clk), .en(en), .num(num_tu), .den(cfg.patches_u), .quo(quo_tu)
  );
  usvg_divider #(.NUM_W(NUM_W), .DEN_W(11), .QUO_W(QUO_W)) u_div_tv (
    .clk(clk), .en(en), .num(num_tv), .den(cfg.patches_v), .quo(quo_tv)
  );

  logic signed [ANG_W-1:0] qs_u, qs_v;

  always_comb begin
    qs_u = sd[QUO_W].neg_u ? -$signed({1'b0, quo_u}) : $signed({1'b0, quo_u});
    qs_v = sd[QUO_W].neg_v ? -$signed({1'b0, quo_v}) : $signed({1'b0, quo_v});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item.ang_u <= ANG_W'(cfg.low_u) + qs_u;
      item.ang_v <= ANG_W'(cfg.low_v) + qs_v;
      item.tex_u <= quo_tu;
      item.tex_v <= quo_tv;
      item.ok    <= sd[QUO_W].ok;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/usvg_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decoupling queue
// A four-entry queue of prepared angle transactions between front and back.
// ----------------------------------------------------------------------------
module usvg_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  usvg_pkg::item_t  wdata,
  output logic             q_ready,
  input  wire              pop,
  output logic             q_valid,
  output usvg_pkg::item_t  rdata
);
  import usvg_pkg::*;

  item_t      mem [0:3];
  logic [1:0] wptr, rptr;
  logic [2:0] count;

  assign q_ready = count != 3'd4;
  assign q_valid = count != 3'd0;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 2'd1;
      end
      if (pop) begin
        rptr <= rptr + 2'd1;
      end
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/usvg_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined CORDIC sine and cosine
// Folds a Q5.13 angle into the right half plane and rotates one stage per
// iteration with 30 fraction bits into Q2.30 sine and cosine.
// ----------------------------------------------------------------------------
module usvg_cordic #(
  parameter int STAGES = usvg_pkg::TRIG_STAGES_DEF
) (
  input  wire                              clk,
  input  wire                              en,
  input  wire signed [usvg_pkg::ANG_W-1:0] ang,
  output logic signed [usvg_pkg::TRIG_W-1:0] sin_q,
  output logic signed [usvg_pkg::TRIG_W-1:0] cos_q
);
  import usvg_pkg::*;

  logic signed [CX_W-1:0] x [0:STAGES];
  logic signed [CX_W-1:0] y [0:STAGES];
  logic signed [CA_W-1:0] a [0:STAGES];
  logic                   flip [0:STAGES];

  logic signed [CA_W-1:0] a_in, a_w;
  logic signed [CA_W-1:0] a_f;
  logic                   fl;

  always_comb begin
    a_in = CA_W'(ang) <<< 17;
    if (a_in > Q30_PI) begin
      a_w = a_in - Q30_TWO_PI;
    end else if (a_in < -Q30_PI) begin
      a_w = a_in + Q30_TWO_PI;
    end else begin
      a_w = a_in;
    end
    if (a_w > Q30_HALF_PI) begin
      a_f = Q30_PI - a_w;
      fl  = 1'b1;
    end else if (a_w < -Q30_HALF_PI) begin
      a_f = -Q30_PI - a_w;
      fl  = 1'b1;
    end else begin
      a_f = a_w;
      fl  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= CORDIC_GAIN;
      y[0]    <= '0;
      a[0]    <= a_f;
      flip[0] <= fl;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (!a[i][CA_W-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          a[i+1] <= a[i] - atan_q30(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          a[i+1] <= a[i] + atan_q30(i);
        end
      end
    end
  end

  assign cos_q = clamp_q30(flip[STAGES] ? -x[STAGES] : x[STAGES]);
  assign sin_q = clamp_q30(y[STAGES]);

endmodule
`default_nettype wire

// ----- hdl/usvg_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Back end
// Takes prepared angles from the queue, evaluates the trigonometry and
// forms position, normal and texture outputs in an output register.
// ----------------------------------------------------------------------------
module usvg_back #(
  parameter int TRIG_STAGES = usvg_pkg::TRIG_STAGES_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire [15:0]         radius,
  input  wire                q_valid,
  input  usvg_pkg::item_t    qdata,
  output logic               pop,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [16:0] pos_x,
  output logic signed [16:0] pos_y,
  output logic signed [16:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [16:0]        tex_u,
  output logic [16:0]        tex_v,
  output logic               index_ok
);
  import usvg_pkg::*;

  localparam int L = TRIG_STAGES + 1;

  logic           en;
  logic [L-1:0]   vt;
  logic           vp;
  side_t          sd [0:L];

  logic signed [TRIG_W-1:0] su, cu, sv, cv;
  logic signed [TRIG_W-1:0] fx, fy, fz;
  logic signed [63:0]       pxy, pyy;

  assign en  = !out_valid || out_ready;
  assign pop = q_valid && en;

  usvg_cordic #(.STAGES(TRIG_STAGES)) u_cordic_u (
    .clk(clk), .en(en), .ang(qdata.ang_u), .sin_q(su), .cos_q(cu)
  );
  usvg_cordic #(.STAGES(TRIG_STAGES)) u_cordic_v (
    .clk(clk), .en(en), .ang(qdata.ang_v), .sin_q(sv), .cos_q(cv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vt        <= '0;
      vp        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vt        <= {vt[L-2:0], q_valid};
      vp        <= vt[L-1];
      out_valid <= vp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= '{tex_u: qdata.tex_u, tex_v: qdata.tex_v, ok: qdata.ok};
      for (int s = 0; s < L; s++) begin
        sd[s+1] <= sd[s];
      end
    end
  end

  always_comb begin
    pxy = (64'(cu) * 64'(cv)) + 64'sd536870912;
    pyy = (64'(su) * 64'(cv)) + 64'sd536870912;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx <= pxy[61:30];
      fy <= pyy[61:30];
      fz <= sv;
    end
  end

  function automatic logic signed [16:0] pos_of(input logic [15:0] r,
                                               input logic signed [TRIG_W-1:0] f);
    logic signed [49:0] p;
    logic signed [19:0] v;
    p = $signed({1'b0, r}) * f + 50'sd536870912;
    v = p[49:30];
    if (v > 20'sd65535) begin
      v = 20'sd65535;
    end else if (v < -20'sd65535) begin
      v = -20'sd65535;
    end
    return v[16:0];
  endfunction

  function automatic logic signed [15:0] norm_of(input logic signed [TRIG_W-1:0] f);
    logic signed [TRIG_W:0] p;
    logic signed [17:0]     v;
    p = f + 33'sd32768;
    v = -$signed(p[TRIG_W:16]);
    if (v > 18'sd16384) begin
      v = 18'sd16384;
    end else if (v < -18'sd16384) begin
      v = -18'sd16384;
    end
    return v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      if (sd[L].ok) begin
        pos_x  <= pos_of(radius, fx);
        pos_y  <= pos_of(radius, fy);
        pos_z  <= pos_of(radius, fz);
        norm_x <= norm_of(fx);
        norm_y <= norm_of(fy);
        norm_z <= norm_of(fz);
        tex_u  <= sd[L].tex_u;
        tex_v  <= sd[L].tex_v;
      end else begin
        pos_x  <= '0;
        pos_y  <= '0;
        pos_z  <= '0;
        norm_x <= '0;
        norm_y <= '0;
        norm_z <= '0;
        tex_u  <= '0;
        tex_v  <= '0;
      end
      index_ok <= sd[L].ok;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/usvg_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UV sphere vertex generator checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module usvg_checker (
  input wire               clk,
  input wire               rst,
  input wire               out_valid,
  input wire               out_ready,
  input wire signed [16:0] pos_x,
  input wire signed [15:0] norm_x,
  input wire signed [15:0] norm_z,
  input wire [16:0]        tex_u,
  input wire [16:0]        tex_v,
  input wire               index_ok
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(tex_u))
    else $error("Stalled result transaction changed.");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("Result valid directly after reset.");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !index_ok |-> pos_x == 17'sd0 && norm_x == 16'sd0 &&
    tex_u == 17'd0 && tex_v == 17'd0)
    else $error("Invalid index gave non-zero fields.");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_ok |-> tex_u <= 17'd65536 && tex_v <= 17'd65536 &&
    norm_z >= -16'sd16384 && norm_z <= 16'sd16384)
    else $error("Result field out of range.");

endmodule

bind uv_sphere_vertex_generator usvg_checker u_usvg_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .pos_x(pos_x), .norm_x(norm_x), .norm_z(norm_z),
  .tex_u(tex_u), .tex_v(tex_v), .index_ok(index_ok)
);
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator testbench
// Drives grid index pairs through the block under several register settings
// and compares each vertex, normal and texture coordinate with a fixed-point
// sphere predictor held here, with random input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import usvg_pkg::*;

  localparam int MAXP = 1024;
  localparam int STAGES = 16;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic signed [16:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic [16:0] tu, tv;
    logic ok;
  } vertex_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_ready;
  logic [10:0] step_u = '0, step_v = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [16:0] pos_x, pos_y, pos_z;
  logic signed [15:0] norm_x, norm_y, norm_z;
  logic [16:0] tex_u, tex_v;
  logic index_ok;

  uv_sphere_vertex_generator uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .step_u(step_u), .step_v(step_v),
    .out_valid(out_valid), .out_ready(out_ready), .pos_x(pos_x), .pos_y(pos_y),
    .pos_z(pos_z), .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .tex_u(tex_u), .tex_v(tex_v), .index_ok(index_ok)
  );

  longint radius_r, lou_r, hiu_r, lov_r, hiv_r, pu_r, pv_r;
  vertex_t expected_vertices[$];
  int errors = 0;
  longint cycles = 0;
  int hold_off = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint step_angle(longint lo, longint hi, longint st, longint p);
    longint n, mag, q;
    n = (hi - lo) * st;
    mag = n < 0 ? -n : n;
    q = (mag + p / 2) / p;
    return lo + (n < 0 ? -q : q);
  endfunction

  function automatic longint arctan_entry(int i);
    longint t[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
    return t[i];
  endfunction

  task automatic rotate(input longint ang, output longint s, output longint c);
    longint a, x, y, dx, dy;
    bit flip;
    a = ang * 131072;
    x = 652032874;
    y = 0;
    flip = 0;
    if (a > 64'sd3373259426) a -= 64'sd6746518852;
    else if (a < -64'sd3373259426) a += 64'sd6746518852;
    if (a > 64'sd1686629713) begin
      a = 64'sd3373259426 - a;
      flip = 1;
    end else if (a < -64'sd1686629713) begin
      a = -64'sd3373259426 - a;
      flip = 1;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (a >= 0) begin
        x -= dx; y += dy; a -= arctan_entry(i);
      end else begin
        x += dx; y -= dy; a += arctan_entry(i);
      end
    end
    if (flip) x = -x;
    c = clip(x, -(64'sd1 <<< 30), 64'sd1 <<< 30);
    s = clip(y, -(64'sd1 <<< 30), 64'sd1 <<< 30);
  endtask

  task automatic predict_vertex(input longint su, input longint sv, output vertex_t r);
    longint u, v, snu, csu, snv, csv, fx, fy;
    r = '{default: 0};
    if (!(pu_r >= 1 && pu_r <= MAXP && pv_r >= 1 && pv_r <= MAXP && su <= pu_r &&
          sv <= pv_r)) return;
    u = step_angle(lou_r, hiu_r, su, pu_r);
    v = step_angle(lov_r, hiv_r, sv, pv_r);
    rotate(u, snu, csu);
    rotate(v, snv, csv);
    fx = rshift(csu * csv, 30);
    fy = rshift(snu * csv, 30);
    r.px = 17'(clip(rshift(radius_r * fx, 30), -65535, 65535));
    r.py = 17'(clip(rshift(radius_r * fy, 30), -65535, 65535));
    r.pz = 17'(clip(rshift(radius_r * snv, 30), -65535, 65535));
    r.nx = 16'(clip(-rshift(fx, 16), -16384, 16384));
    r.ny = 16'(clip(-rshift(fy, 16), -16384, 16384));
    r.nz = 16'(clip(-rshift(snv, 16), -16384, 16384));
    r.tu = 17'((su * 65536 + pu_r / 2) / pu_r);
    r.tv = 17'((sv * 65536 + pv_r / 2) / pv_r);
    r.ok = 1'b1;
  endtask

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("Mismatch on %s: got %0d, expected %0d", what, got, want);
  endtask

  task automatic write_reg(input logic [2:0] idx, input longint val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {idx, 2'b00}; pwdata <= val[31:0];
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_RADIUS: radius_r = val & 16'hFFFF;
      REG_LOW_U: lou_r = longint'(signed'(16'(val)));
      REG_HIGH_U: hiu_r = longint'(signed'(16'(val)));
      REG_LOW_V: lov_r = longint'(signed'(15'(val)));
      REG_HIGH_V: hiv_r = longint'(signed'(15'(val)));
      REG_PATCHES_U: pu_r = val & 11'h7FF;
      REG_PATCHES_V: pv_r = val & 11'h7FF;
      default: ;
    endcase
  endtask

  task automatic send_point(input int su, input int sv, input bit gaps);
    vertex_t e;
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3))
        @(negedge clk);
    end
    predict_vertex(su, sv, e);
    expected_vertices.insert(expected_vertices.size(), e);
    in_valid <= 1;
    step_u <= 11'(su);
    step_v <= 11'(sv);
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    vertex_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_vertices.size() == 0) begin
        errors++;
        $display("Unexpected vertex transaction");
      end else begin
        e = expected_vertices.pop_front();
        if (pos_x !== e.px) report("pos_x", pos_x, e.px);
        if (pos_y !== e.py) report("pos_y", pos_y, e.py);
        if (pos_z !== e.pz) report("pos_z", pos_z, e.pz);
        if (norm_x !== e.nx) report("norm_x", norm_x, e.nx);
        if (norm_y !== e.ny) report("norm_y", norm_y, e.ny);
        if (norm_z !== e.nz) report("norm_z", norm_z, e.nz);
        if (tex_u !== e.tu) report("tex_u", tex_u, e.tu);
        if (tex_v !== e.tv) report("tex_v", tex_v, e.tv);
        if (index_ok !== e.ok) report("index_ok", index_ok, e.ok);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 0;
      hold_off <= hold_off - 1;
    end else if ($urandom_range(0, 99) < 8) begin
      out_ready <= 0;
      if ($urandom_range(0, 19) == 0) hold_off <= $urandom_range(5, 40);
    end else begin
      out_ready <= 1;
    end
  end

  task automatic drain();
    in_valid <= 0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (STAGES + 40) @(posedge clk);
  endtask

  task automatic test_directed_extremes();
    send_point(0, 0, 0);
    send_point(32, 32, 0);
    send_point(16, 16, 0);
    send_point(33, 0, 0);
    send_point(0, 33, 0);
    send_point(2047, 2047, 0);
    send_point(1024, 5, 0);
    send_point(8, 0, 0);
    send_point(8, 32, 0);
    send_point(24, 16, 0);
    drain();
  endtask

  task automatic test_settings_sweep();
    longint vals[7];
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: vals = '{65535, -25736, 25736, -12868, 12868, 1024, 1024};
        1: vals = '{0, 25736, -25736, 12868, -12868, 1, 1};
        2: vals = '{1, 32767, -32768, 16383, -16384, 7, 3};
        3: vals = '{65535, -32768, 32767, -16384, 16383, 0, 5};
        4: vals = '{256, 0, 25736, -12868, 0, 1025, 2047};
        default: begin
          vals[0] = $urandom_range(0, 65535);
          vals[1] = $urandom_range(0, 65535);
          vals[2] = $urandom_range(0, 65535);
          vals[3] = $urandom_range(0, 32767);
          vals[4] = $urandom_range(0, 32767);
          vals[5] = $urandom_range(1, 64);
          vals[6] = $urandom_range(1, 64);
        end
      endcase
      for (int r = 0; r < 7; r++) write_reg(r[2:0], vals[r]);
      for (int n = 0; n < 180; n++) begin
        if ($urandom_range(0, 9) == 0)
          send_point($urandom_range(0, 2047), $urandom_range(0, 2047), 1);
        else
          send_point($urandom_range(0, pu_r > 1024 ? 1024 : pu_r),
                     $urandom_range(0, pv_r > 1024 ? 1024 : pv_r), 1);
      end
      drain();
    end
  endtask

  task automatic test_output_stall();
    write_reg(REG_PATCHES_U, 1024);
    write_reg(REG_PATCHES_V, 1024);
    @(posedge clk);
    hold_off = 300;
    for (int n = 0; n < 80; n++)
      send_point($urandom_range(0, 1024), $urandom_range(0, 1024), 0);
    drain();
  endtask

  initial begin
    radius_r = 256; lou_r = -25736; hiu_r = 25736; lov_r = -12868; hiv_r = 12868;
    pu_r = 32; pv_r = 32;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed_extremes();
    test_settings_sweep();
    test_output_stall();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/usvg_pkg.sv
hdl/usvg_divider.sv
hdl/usvg_front.sv
hdl/usvg_queue.sv
hdl/usvg_cordic.sv
hdl/usvg_back.sv
hdl/uv_sphere_vertex_generator.sv
hdl/usvg_checker.sv
dv/testbench.sv
